### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic REG_IS_MAX_MODE = 1'b0;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [63:0] in_key;
        logic [31:0]        in_data;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] out_key;
        logic [31:0]        out_data;
        logic [1:0]         status;
        logic [4:0]         entry_total;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic cmp;
        logic upd;
    } t_dp_cmd;

endpackage

### design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accept, compare, update; owns both handshakes.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output spq_pkg::t_dp_cmd o_cmd
);
    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_cmd.load_in = 1'b0;
        o_cmd.cmp     = 1'b0;
        o_cmd.upd     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.upd   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### design/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Row of sorted cells with parallel key compare, entry count and result
// register.
// ----------------------------------------------------------------------------
module spq_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  spq_pkg::t_in_item  i_in_item,
    input  logic               i_is_max,
    output spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    t_in_item           r_in;
    logic signed [63:0] r_key [CAPACITY];
    logic [31:0]        r_tag [CAPACITY];
    logic signed [63:0] n_key [CAPACITY];
    logic [31:0]        n_tag [CAPACITY];
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CAPACITY-1:0] r_beat, n_beat;
    logic [CAPACITY-1:0] pfx, pfx_prev, first;
    t_out_item          r_res, n_res;
    logic               full, empty;

    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign o_out_item = r_res;

    // new key goes in front of the first cell it strictly beats, or into the first free cell
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        assign n_beat[i] = (IDX >= r_count) ||
                           (i_is_max ? (r_in.in_key > r_key[i]) :
                                       (r_in.in_key < r_key[i]));
        assign pfx[i]    = |r_beat[i:0];
    end

    assign pfx_prev = {pfx[CAPACITY-2:0], 1'b0};
    assign first    = pfx & ~pfx_prev;

    always_comb begin
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_key[i] = r_key[i];
            n_tag[i] = r_tag[i];
        end
        n_res.out_key  = '0;
        n_res.out_data = '0;
        n_res.status   = ST_OK;
        unique case (r_in.operation) inside
            OP_INSERT: begin
                if (full) begin
                    n_res.status = ST_FULL;
                end else begin
                    if (first[0]) begin
                        n_key[0] = r_in.in_key;
                        n_tag[0] = r_in.in_data;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (first[i]) begin
                            n_key[i] = r_in.in_key;
                            n_tag[i] = r_in.in_data;
                        end else if (pfx[i]) begin
                            n_key[i] = r_key[i-1];
                            n_tag[i] = r_tag[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_REMOVE, OP_PEEK: begin
                if (empty) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_res.out_key  = r_key[0];
                    n_res.out_data = r_tag[0];
                    if (r_in.operation == OP_REMOVE) begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            n_key[i] = r_key[i+1];
                            n_tag[i] = r_tag[i+1];
                        end
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_res.entry_total = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.cmp) begin
            r_beat <= n_beat;
        end
        if (i_cmd.upd) begin
            r_res <= n_res;
            for (int i = 0; i < CAPACITY; i++) begin
                r_key[i] <= n_key[i];
                r_tag[i] <= n_tag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.upd) begin
            r_count <= n_count;
        end
    end

endmodule

### design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted by a signed 64-bit key, with a mode
// register for largest-first or smallest-first service.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall | o_out_item (t_out_item)
//   cfg     | input     | apb psel / penable     | paddr, pwdata, prdata
//
// each beat runs through accept, parallel compare of all cells, update
// of the cell row and result register, stalling input until done
// the update waits while the result register holds a stalled beat
// reset empties the queue and selects largest-first; stored cells are not
// cleared
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import spq_pkg::*;

    t_dp_cmd cmd;
    logic    r_is_max;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IS_MAX_MODE) ? {31'b0, r_is_max} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_max <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_IS_MAX_MODE) begin
            r_is_max <= pwdata[0];
        end
    end

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    spq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_is_max   (r_is_max),
        .o_out_item (o_out_item)
    );

endmodule

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input spq_pkg::t_out_item o_out_item
);
    import spq_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result beat changed");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    a_total_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.entry_total <= 5'(CAPACITY))
        else $error("entry total above capacity");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_FULL |->
            o_out_item.entry_total == 5'(CAPACITY) && o_out_item.out_key == '0)
        else $error("full status with room left");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_EMPTY |->
            o_out_item.entry_total == '0 && o_out_item.out_data == '0)
        else $error("empty status with entries held");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
